// ===== design/ils_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ils_pkg
// Request and status codes shared by the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

    typedef logic [1:0] t_req;
    typedef logic [1:0] t_status;

    localparam t_req REQ_APPEND = 2'd0;
    localparam t_req REQ_INSERT = 2'd1;
    localparam t_req REQ_POP    = 2'd2;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

endpackage
`default_nettype wire

// ===== design/indexed_list_store_top.sv =====
// An error or an unused request code returns its beat in the cycle after accept.
// Append and insert pass through prime and move states, rippling entries up from index p to the end.
// Pop passes through prime, capture and move states, closing the gap from index i to the end.
// One entry moves per cycle through the store's single write port; one request at a time,
// the next beat is taken the cycle after the result beat leaves.
// Reset clears the entry count and control state; store contents are not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Bounded ordered list of value handles with append, insert at index and
// pop (last or at index, negative index counts from the end).
// ----------------------------------------------------------------------------
module indexed_list_store_top #(
    parameter int LIST_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire ils_pkg::t_req    i_req_type,
    input  wire logic             i_use_index,
    input  wire logic [7:0]       i_position,
    input  wire logic [31:0]      i_item_value,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output ils_pkg::t_status      o_status,
    output logic [31:0]           o_popped_value,
    output logic [6:0]            o_entry_count
);
    import ils_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int SW = ((CW > 8) ? CW : 8) + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRIME = 3'd1;
    localparam logic [2:0] S_CAP   = 3'd2;
    localparam logic [2:0] S_MOVE  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [CW-1:0]          r_ptr, n_ptr;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [VALUE_WIDTH-1:0] r_carry, n_carry;
    logic [VALUE_WIDTH-1:0] r_pop, n_pop;
    t_status                r_status, n_status;
    logic                   r_is_pop, n_is_pop;

    logic [VALUE_WIDTH-1:0] r_mem [LIST_DEPTH];
    logic [VALUE_WIDTH-1:0] r_rdata;
    logic                   w_we;
    logic [AW-1:0]          w_waddr, w_raddr;
    logic [VALUE_WIDTH-1:0] w_wdata;

    logic [63:0]            w_val64, w_pop64, w_cnt64;
    logic [SW-1:0]          w_pos_s, w_cnt_s, w_idx_s;
    logic [CW-1:0]          w_ptr_p1, w_ptr_p2;
    logic                   w_full, w_ins_bad, w_pop_bad;

    assign w_val64  = {32'd0, i_item_value};
    assign w_pos_s  = {{(SW-8){i_position[7]}}, i_position};
    assign w_cnt_s  = SW'(r_cnt);
    assign w_full   = (r_cnt == CW'(LIST_DEPTH));
    assign w_ins_bad = i_position[7] || (w_pos_s > w_cnt_s);
    assign w_idx_s  = !i_use_index ? (w_cnt_s - SW'(1)) :
                      (i_position[7] ? (w_pos_s + w_cnt_s) : w_pos_s);
    assign w_pop_bad = (r_cnt == '0) || w_idx_s[SW-1] || (w_idx_s >= w_cnt_s);
    assign w_ptr_p1 = r_ptr + CW'(1);
    assign w_ptr_p2 = r_ptr + CW'(2);

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_cnt    = r_cnt;
        n_carry  = r_carry;
        n_pop    = r_pop;
        n_status = r_status;
        n_is_pop = r_is_pop;
        w_we     = 1'b0;
        w_waddr  = r_ptr[AW-1:0];
        w_wdata  = r_carry;
        w_raddr  = r_ptr[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_pop    = '0;
                    n_status = ST_OK;
                    n_carry  = w_val64[VALUE_WIDTH-1:0];
                    n_state  = S_DONE;
                    case (i_req_type)
                        REQ_APPEND: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_ptr    = r_cnt;
                                n_is_pop = 1'b0;
                                n_state  = S_PRIME;
                            end
                        end
                        REQ_INSERT: begin
                            if (w_ins_bad) begin
                                n_status = ST_RANGE;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_ptr    = w_pos_s[CW-1:0];
                                n_is_pop = 1'b0;
                                n_state  = S_PRIME;
                            end
                        end
                        REQ_POP: begin
                            if (w_pop_bad) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_ptr    = w_idx_s[CW-1:0];
                                n_is_pop = 1'b1;
                                n_state  = S_PRIME;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PRIME: begin
                n_state = r_is_pop ? S_CAP : S_MOVE;
            end
            S_CAP: begin
                n_pop   = r_rdata;
                w_raddr = w_ptr_p1[AW-1:0];
                n_state = S_MOVE;
            end
            S_MOVE: begin
                if (r_is_pop) begin
                    // close the gap: entry k takes old entry k+1
                    if (w_ptr_p1 >= r_cnt) begin
                        n_cnt   = r_cnt - CW'(1);
                        n_state = S_DONE;
                    end else begin
                        w_we    = 1'b1;
                        w_wdata = r_rdata;
                        w_raddr = w_ptr_p2[AW-1:0];
                        n_ptr   = w_ptr_p1;
                    end
                end else begin
                    // ripple up: write carried value, carry old entry
                    w_we    = 1'b1;
                    w_wdata = r_carry;
                    n_carry = r_rdata;
                    w_raddr = w_ptr_p1[AW-1:0];
                    n_ptr   = w_ptr_p1;
                    if (r_ptr == r_cnt) begin
                        n_cnt   = r_cnt + CW'(1);
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_ptr    <= n_ptr;
        r_carry  <= n_carry;
        r_pop    <= n_pop;
        r_status <= n_status;
        r_is_pop <= n_is_pop;
    end

    assign w_pop64 = 64'(r_pop);
    assign w_cnt64 = 64'(r_cnt);

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_DONE);
    assign o_status       = r_status;
    assign o_popped_value = w_pop64[31:0];
    assign o_entry_count  = w_cnt64[6:0];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(LIST_DEPTH))
        else $error("entry count above depth");

    a_write_in_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_MOVE))
        else $error("store written outside move phase");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_status == ST_FULL) |-> w_full)
        else $error("full status with room left");

    a_fail_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_status != ST_OK) |-> (r_pop == '0))
        else $error("failed request returned a value");

    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_valid) |=> $stable(r_cnt))
        else $error("entry count changed while idle");

endmodule
`default_nettype wire

// ===== tb/tb_indexed_list_store_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_indexed_list_store_top
// Self-checking bench for the indexed list store. A directed table covers
// the edge cases: empty, out of range, negative index and the unused
// request code. Random phases then push the list between empty and full.
// A local list model predicts untyped result beats, and each beat is compared
// field by field in order. Both sides idle at random, and at least once the
// receiver is held off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_indexed_list_store_top;
    import ils_pkg::*;

    localparam int LIST_DEPTH     = 64;
    localparam int VALUE_WIDTH    = 32;
    localparam int CLK_HALF       = 6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = LIST_DEPTH + 8;
    localparam int NUM_PHASES     = 15;
    localparam int PHASE_ITEMS    = 100;
    localparam int NUM_DIR        = 22;
    localparam int HOLD_PHASE     = 4;
    localparam int PAUSE_PHASE    = 8;
    localparam int GROW_PCT [NUM_PHASES] =
        '{85, 85, 50, 15, 15, 70, 30, 50, 90, 10, 60, 40, 85, 20, 50};

    localparam t_req REQ_UNUSED = 2'd3;

    typedef struct packed {
        t_status     status;
        logic [31:0] popped;
        logic [6:0]  count;
    } list_result_t;

    typedef struct packed {
        t_req         req;
        logic         use_idx;
        logic [7:0]   pos;
        logic [31:0]  val;
        logic         typed;
        list_result_t want;
    } dir_row_t;

    // typed rows carry their result; the rest go through the model
    localparam dir_row_t DIR_TABLE [NUM_DIR] = '{
        '{REQ_POP,    1'b0, 8'h00, 32'h0000_0000, 1'b1, '{ST_RANGE, 32'h0, 7'd0}},
        '{REQ_POP,    1'b1, 8'h00, 32'h0000_0000, 1'b1, '{ST_RANGE, 32'h0, 7'd0}},
        '{REQ_INSERT, 1'b0, 8'h01, 32'h1111_1111, 1'b1, '{ST_RANGE, 32'h0, 7'd0}},
        '{REQ_INSERT, 1'b1, 8'h80, 32'h2222_2222, 1'b1, '{ST_RANGE, 32'h0, 7'd0}},
        '{REQ_APPEND, 1'b1, 8'h7F, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0, 7'd1}},
        '{REQ_APPEND, 1'b0, 8'hFF, 32'h0000_0000, 1'b1, '{ST_OK,    32'h0, 7'd2}},
        '{REQ_INSERT, 1'b0, 8'h00, 32'hA5A5_A5A5, 1'b1, '{ST_OK,    32'h0, 7'd3}},
        '{REQ_INSERT, 1'b0, 8'h03, 32'h5A5A_5A5A, 1'b1, '{ST_OK,    32'h0, 7'd4}},
        '{REQ_INSERT, 1'b0, 8'h05, 32'h3333_3333, 1'b1, '{ST_RANGE, 32'h0, 7'd4}},
        '{REQ_INSERT, 1'b0, 8'h7F, 32'h4444_4444, 1'b1, '{ST_RANGE, 32'h0, 7'd4}},
        '{REQ_UNUSED, 1'b1, 8'h55, 32'hDEAD_BEEF, 1'b1, '{ST_OK,    32'h0, 7'd4}},
        '{REQ_POP,    1'b1, 8'hFF, 32'h0000_0000, 1'b0, '0},
        '{REQ_POP,    1'b1, 8'h80, 32'h0000_0000, 1'b1, '{ST_RANGE, 32'h0, 7'd3}},
        '{REQ_POP,    1'b1, 8'h03, 32'h0000_0000, 1'b1, '{ST_RANGE, 32'h0, 7'd3}},
        '{REQ_POP,    1'b1, 8'hFC, 32'h0000_0000, 1'b1, '{ST_RANGE, 32'h0, 7'd3}},
        '{REQ_POP,    1'b1, 8'hFD, 32'h0000_0000, 1'b0, '0},
        '{REQ_INSERT, 1'b0, 8'h01, 32'h0000_0001, 1'b0, '0},
        '{REQ_POP,    1'b1, 8'h01, 32'h0000_0000, 1'b0, '0},
        '{REQ_POP,    1'b0, 8'h80, 32'h0000_0000, 1'b0, '0},
        '{REQ_POP,    1'b0, 8'h00, 32'h0000_0000, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 7'd0}},
        '{REQ_POP,    1'b0, 8'h00, 32'h0000_0000, 1'b1, '{ST_RANGE, 32'h0, 7'd0}},
        '{REQ_APPEND, 1'b0, 8'h00, 32'h8000_0000, 1'b0, '0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_req        i_req_type;
    logic        i_use_index;
    logic [7:0]  i_position;
    logic [31:0] i_item_value;
    logic        o_valid;
    logic        i_ready;
    t_status     o_status;
    logic [31:0] o_popped_value;
    logic [6:0]  o_entry_count;

    logic [31:0]  list_mem [LIST_DEPTH];
    int           list_len;
    list_result_t pending_results [$];
    int           mismatch_count = 0;
    int           idle_cycles = 0;
    bit           no_idle = 1'b0;
    bit           hold_off = 1'b0;

    indexed_list_store_top #(
        .LIST_DEPTH  (LIST_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_use_index    (i_use_index),
        .i_position     (i_position),
        .i_item_value   (i_item_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_entry_count  (o_entry_count)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    function automatic list_result_t list_apply(t_req req, logic use_idx, logic [7:0] pos,
                                                logic [31:0] val);
        list_result_t r;
        int           p;
        int           idx;
        r        = '0;
        r.status = ST_OK;
        p        = int'($signed(pos));
        case (req)
            REQ_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            end
            REQ_INSERT: begin
                if (p < 0 || p > list_len) begin
                    r.status = ST_RANGE;
                end else if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int k = list_len; k > p; k--) list_mem[k] = list_mem[k - 1];
                    list_mem[p] = val;
                    list_len++;
                end
            end
            REQ_POP: begin
                if (list_len == 0) begin
                    r.status = ST_RANGE;
                end else begin
                    idx = use_idx ? p : list_len - 1;
                    if (use_idx && idx < 0) idx += list_len;
                    if (idx < 0 || idx >= list_len) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.popped = list_mem[idx];
                        for (int k = idx; k + 1 < list_len; k++) list_mem[k] = list_mem[k + 1];
                        list_len--;
                    end
                end
            end
            default: ;
        endcase
        r.count = 7'(list_len);
        return r;
    endfunction

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 15);
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_beat(t_req req, logic use_idx, logic [7:0] pos, logic [31:0] val,
                             logic typed, list_result_t want);
        list_result_t got;
        int           gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_use_index  <= use_idx;
        i_position   <= pos;
        i_item_value <= val;
        do @(posedge i_clk); while (!o_ready);
        got = list_apply(req, use_idx, pos, val);
        pending_results.push_back(typed ? want : got);
    endtask

    initial begin : stim
        t_req        req;
        logic        use_idx;
        logic [7:0]  pos;
        logic [31:0] val;
        int          n;
        int          grow;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_req_type   <= REQ_APPEND;
        i_use_index  <= 1'b0;
        i_position   <= 8'h00;
        i_item_value <= 32'h0;
        list_len = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIR; i++) begin
            send_beat(DIR_TABLE[i].req, DIR_TABLE[i].use_idx, DIR_TABLE[i].pos,
                      DIR_TABLE[i].val, DIR_TABLE[i].typed, DIR_TABLE[i].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            grow    = GROW_PCT[ph];
            no_idle = ($urandom_range(0, 4) == 0);
            if (ph == HOLD_PHASE) begin
                no_idle  = 1'b1;
                hold_off = 1'b1;
            end
            if (ph == PAUSE_PHASE) begin
                i_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            n = 0;
            while (n < PHASE_ITEMS) begin
                use_idx = ($urandom_range(0, 9) < 7);
                pos     = 8'($urandom);
                val     = $urandom;
                case ($urandom_range(0, 7))
                    0: val = 32'h0;
                    1: val = 32'hFFFF_FFFF;
                    default: ;
                endcase
                if ($urandom_range(0, 99) < 4) begin
                    req = REQ_UNUSED;
                end else if ($urandom_range(0, 99) < grow) begin
                    req = $urandom_range(0, 1) ? REQ_APPEND : REQ_INSERT;
                    if ($urandom_range(0, 4) != 0) pos = 8'($urandom_range(0, list_len));
                end else begin
                    req = REQ_POP;
                    if ($urandom_range(0, 4) != 0 && list_len > 0)
                        pos = 8'(int'($urandom_range(0, 2 * list_len - 1)) - list_len);
                end
                send_beat(req, use_idx, pos, val, 1'b0, '0);
                if (req != REQ_UNUSED) n++;
            end
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_indexed_list_store_top OK");
        end else begin
            $display("tb_indexed_list_store_top NOT OK");
        end
        $finish;
    end

    initial begin : sink
        int gap;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end else begin
                gap = draw_gap();
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin : check_beat
        list_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_popped_value !== want.popped)
                    report_mismatch($sformatf("popped_value %08h, want %08h",
                                              o_popped_value, want.popped));
                if (o_entry_count !== want.count)
                    report_mismatch($sformatf("entry_count %0d, want %0d",
                                              o_entry_count, want.count));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_indexed_list_store_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
`default_nettype wire
